// ----- rtl/core/ialu_pkg.sv -----
// Opcode, status and width constants for the 64-bit integer ALU.
// No dependencies; used by integer_alu_64bit.
package ialu_pkg;

   localparam int REQ_TDATA_W = 200;   // 5 + 64 + 64 + 64 = 197, rounded up to bytes
   localparam int RSP_TDATA_W = 72;    // 64 + 2 = 66, rounded up to bytes
   localparam int FIELD_W     = 64;    // external operand / result field width

   typedef logic [4:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_ADD  = 5'd0;
   localparam op_type OP_SUB  = 5'd1;
   localparam op_type OP_MUL  = 5'd2;
   localparam op_type OP_MULH = 5'd3;
   localparam op_type OP_MAD  = 5'd4;
   localparam op_type OP_DIV  = 5'd5;
   localparam op_type OP_REM  = 5'd6;
   localparam op_type OP_EQ   = 5'd7;
   localparam op_type OP_NE   = 5'd8;
   localparam op_type OP_LT   = 5'd9;
   localparam op_type OP_LE   = 5'd10;
   localparam op_type OP_SHL  = 5'd11;
   localparam op_type OP_SHR  = 5'd12;
   localparam op_type OP_SAR  = 5'd13;
   localparam op_type OP_OR   = 5'd14;
   localparam op_type OP_AND  = 5'd15;
   localparam op_type OP_XOR  = 5'd16;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_BAD_OP  = 2'd1;
   localparam status_type ST_DIV_ZERO = 2'd2;

endpackage

// ----- rtl/core/integer_alu_64bit.sv -----
// Pipelined 64-bit signed integer ALU: add/sub/mul/mulh/mad/div/rem/compare/shift/logic.
// Depends on ialu_pkg (opcodes, status codes, bus widths).
//
//  channel | dir | tdata fields (low bit first)                         | accepted when
//  --------+-----+------------------------------------------------------+---------------------
//  req     | in  | req_type[4:0], operand_a[68:5], operand_b[132:69],    | req_tvalid&req_tready
//          |     | scale_factor[196:133], zero fill [199:197]           |
//  rsp     | out | result_value[63:0], status_code[65:64], zero [71:66] | rsp_tvalid&rsp_tready
//
// DATA_WIDTH + 3 register stages: input, prep, divide steps and output. The divider is a
// restoring array with one quotient bit per stage, and every opcode rides the same pipe so
// results leave in order. One transaction enters per cycle unless the pipe is full and the
// output is stalled.
// Each stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles squeeze out and a stalled output holds only the tail.
// Synchronous active-high reset clears the valid bits only.
module integer_alu_64bit #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_type, operand_a, operand_b, scale_factor (low bit first), zero fill
   input  logic [ialu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_value, status_code (low bit first), zero fill
   output logic [ialu_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int W      = DATA_WIDTH;
   localparam int NSTAGE = W + 3;      // input, prep, W divide steps, output
   localparam int LAST   = NSTAGE - 1;

   // ---- per-stage control -------------------------------------------------------
   logic                   vld_ff [NSTAGE];
   logic                   rdy    [NSTAGE+1];
   ialu_pkg::op_type       op_ff  [NSTAGE];
   ialu_pkg::status_type   st_ff  [1:LAST];
   logic [W-1:0]           res_ff [1:LAST];

   // stage 0 operands
   logic [W-1:0] a0_ff, b0_ff, sc0_ff;

   // divider state, stages 1 .. W+1
   logic [W-1:0] rem_ff [1:W+1];
   logic [W-1:0] quo_ff [1:W+1];
   logic [W-1:0] dvs_ff [1:W+1];
   logic         nga_ff [1:W+1];
   logic         ngb_ff [1:W+1];

   // multiplier partial products (stage 1) and sums (stage 2)
   logic [63:0]  p0_ff, p1_ff, p2_ff, p3_ff, q0_ff, q1_ff, q2_ff;
   logic [127:0] prod2_ff;
   logic [63:0]  bsc2_ff;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      rdy[NSTAGE] = rsp_tready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid;
         for (int k = 1; k < NSTAGE; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ---- stage 0: input register -------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op_ff[0] <= req_tdata[4:0];
         a0_ff    <= req_tdata[5 +: W];
         b0_ff    <= req_tdata[69 +: W];
         sc0_ff   <= req_tdata[133 +: W];
      end
   end

   // ---- stage 1: simple ops, divide prep, partial products ----------------------
   logic [5:0]            sh;
   logic                  na, nb;
   logic [W-1:0]          res1_in, corr;
   ialu_pkg::status_type  st1_in;
   logic [63:0]           ua, ub, us;

   always_comb begin
      sh   = b0_ff[5:0];
      na   = a0_ff[W-1];
      nb   = b0_ff[W-1];
      corr = (na ? b0_ff : '0) + (nb ? a0_ff : '0);
      ua   = 64'(a0_ff);
      ub   = 64'(b0_ff);
      us   = 64'(sc0_ff);
      st1_in = ialu_pkg::ST_OK;
      case (op_ff[0])
         ialu_pkg::OP_ADD:  res1_in = a0_ff + b0_ff;
         ialu_pkg::OP_SUB:  res1_in = a0_ff - b0_ff;
         ialu_pkg::OP_MULH: res1_in = corr;      // subtracted from the high half later
         ialu_pkg::OP_MAD:  res1_in = a0_ff;     // b*scale added later
         ialu_pkg::OP_EQ:   res1_in = W'(a0_ff == b0_ff);
         ialu_pkg::OP_NE:   res1_in = W'(a0_ff != b0_ff);
         ialu_pkg::OP_LT:   res1_in = W'($signed(a0_ff) < $signed(b0_ff));
         ialu_pkg::OP_LE:   res1_in = W'($signed(a0_ff) <= $signed(b0_ff));
         ialu_pkg::OP_SHL:  res1_in = a0_ff << sh;
         ialu_pkg::OP_SHR:  res1_in = a0_ff >> sh;
         ialu_pkg::OP_SAR:  res1_in = W'($signed(a0_ff) >>> sh);
         ialu_pkg::OP_OR:   res1_in = a0_ff | b0_ff;
         ialu_pkg::OP_AND:  res1_in = a0_ff & b0_ff;
         ialu_pkg::OP_XOR:  res1_in = a0_ff ^ b0_ff;
         default:           res1_in = '0;
      endcase
      if (op_ff[0] > ialu_pkg::OP_XOR) begin
         st1_in = ialu_pkg::ST_BAD_OP;
      end else if ((op_ff[0] == ialu_pkg::OP_DIV || op_ff[0] == ialu_pkg::OP_REM)
                   && b0_ff == '0) begin
         st1_in = ialu_pkg::ST_DIV_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         op_ff[1]  <= op_ff[0];
         st_ff[1]  <= st1_in;
         res_ff[1] <= res1_in;
         rem_ff[1] <= '0;
         quo_ff[1] <= na ? W'(-a0_ff) : a0_ff;
         dvs_ff[1] <= nb ? W'(-b0_ff) : b0_ff;
         nga_ff[1] <= na;
         ngb_ff[1] <= nb;
         p0_ff     <= ua[31:0]  * ub[31:0];
         p1_ff     <= ua[31:0]  * ub[63:32];
         p2_ff     <= ua[63:32] * ub[31:0];
         p3_ff     <= ua[63:32] * ub[63:32];
         q0_ff     <= ub[31:0]  * us[31:0];
         q1_ff     <= ub[31:0]  * us[63:32];
         q2_ff     <= ub[63:32] * us[31:0];
      end
   end

   // ---- stage 2: product sums ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         prod2_ff <= 128'(p0_ff) + (128'(p1_ff) << 32) + (128'(p2_ff) << 32)
                     + (128'(p3_ff) << 64);
         bsc2_ff  <= q0_ff + ((q1_ff + q2_ff) << 32);
      end
   end

   // ---- divide steps: stage k = 2 .. W+1, one quotient bit each -----------------
   for (genvar k = 2; k <= W + 1; k++) begin : g_div
      logic [W:0]   trial;
      logic         take;
      logic [W-1:0] res_in;

      always_comb begin
         trial = {rem_ff[k-1], quo_ff[k-1][W-1]};
         take  = trial >= {1'b0, dvs_ff[k-1]};
         res_in = res_ff[k-1];
         if (k == 3) begin
            case (op_ff[2])
               ialu_pkg::OP_MUL:  res_in = prod2_ff[W-1:0];
               ialu_pkg::OP_MULH: res_in = prod2_ff[2*W-1 -: W] - res_ff[2];
               ialu_pkg::OP_MAD:  res_in = res_ff[2] + bsc2_ff[W-1:0];
               default:           res_in = res_ff[2];
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            op_ff[k]  <= op_ff[k-1];
            st_ff[k]  <= st_ff[k-1];
            res_ff[k] <= res_in;
            rem_ff[k] <= take ? W'(trial - {1'b0, dvs_ff[k-1]}) : trial[W-1:0];
            quo_ff[k] <= {quo_ff[k-1][W-2:0], take};
            dvs_ff[k] <= dvs_ff[k-1];
            nga_ff[k] <= nga_ff[k-1];
            ngb_ff[k] <= ngb_ff[k-1];
         end
      end
   end

   // ---- output stage: sign fix and final select ---------------------------------
   logic [W-1:0] fin_in;

   always_comb begin
      case (op_ff[LAST-1])
         ialu_pkg::OP_DIV: fin_in = (nga_ff[W+1] != ngb_ff[W+1]) ?
                                    W'(-quo_ff[W+1]) : quo_ff[W+1];
         ialu_pkg::OP_REM: fin_in = nga_ff[W+1] ? W'(-rem_ff[W+1]) : rem_ff[W+1];
         default:          fin_in = res_ff[LAST-1];
      endcase
      if (st_ff[LAST-1] != ialu_pkg::ST_OK) fin_in = '0;
   end

   always_ff @(posedge clock) begin
      if (rdy[LAST]) begin
         op_ff[LAST]  <= op_ff[LAST-1];
         st_ff[LAST]  <= st_ff[LAST-1];
         res_ff[LAST] <= fin_in;
      end
   end

   logic [ialu_pkg::FIELD_W-1:0] res_ext;
   assign res_ext   = ialu_pkg::FIELD_W'($signed(res_ff[LAST]));
   assign rsp_tdata = {6'b0, st_ff[LAST], res_ext};

endmodule

// ----- dv/tb_integer_alu_64bit.sv -----
// Self-checking testbench for integer_alu_64bit: directed corner cases, then random traffic.
// Depends on ialu_pkg and the integer_alu_64bit RTL; results are checked in order against
// a behavioral ALU model kept here.
`timescale 1ns / 100ps

module tb_integer_alu_64bit;

   localparam int LATENCY = 67;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0]          value;
      ialu_pkg::status_type status;
   } alu_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // req_type, operand_a, operand_b, scale_factor (low bit first), zero fill
   logic [ialu_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // result_value, status_code (low bit first), zero fill
   logic [ialu_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   alu_result_type expected_q[$];
   int             error_count = 0;
   int             rsp_count = 0;
   int             hold_cycles = 0;   // forces a long receiver stall when nonzero
   bit             rsp_idle_en = 1'b1;

   integer_alu_64bit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Behavioral ALU: signed 64-bit, wrapping, with the block's fixed corner rules.
   function automatic alu_result_type alu_predict(ialu_pkg::op_type op, logic [63:0] a,
                                                  logic [63:0] b, logic [63:0] sc);
      alu_result_type  r;
      logic [127:0]    prod;
      logic [63:0]     ma, mb, q, m;
      logic [5:0]      sh;
      r.value  = '0;
      r.status = ialu_pkg::ST_OK;
      sh = b[5:0];
      case (op)
         ialu_pkg::OP_ADD:  r.value = a + b;
         ialu_pkg::OP_SUB:  r.value = a - b;
         ialu_pkg::OP_MUL:  r.value = a * b;
         ialu_pkg::OP_MULH: begin
            prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
            r.value = prod[127:64];
         end
         ialu_pkg::OP_MAD:  r.value = a + b * sc;
         ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
            if (b == '0) begin
               r.status = ialu_pkg::ST_DIV_ZERO;
            end else begin
               ma = a[63] ? -a : a;
               mb = b[63] ? -b : b;
               q = ma / mb;
               m = ma % mb;
               if (op == ialu_pkg::OP_DIV) r.value = (a[63] != b[63]) ? -q : q;
               else r.value = a[63] ? -m : m;
            end
         end
         ialu_pkg::OP_EQ:   r.value = 64'(a == b);
         ialu_pkg::OP_NE:   r.value = 64'(a != b);
         ialu_pkg::OP_LT:   r.value = 64'($signed(a) < $signed(b));
         ialu_pkg::OP_LE:   r.value = 64'($signed(a) <= $signed(b));
         ialu_pkg::OP_SHL:  r.value = a << sh;
         ialu_pkg::OP_SHR:  r.value = a >> sh;
         ialu_pkg::OP_SAR:  r.value = $signed(a) >>> sh;
         ialu_pkg::OP_OR:   r.value = a | b;
         ialu_pkg::OP_AND:  r.value = a & b;
         ialu_pkg::OP_XOR:  r.value = a ^ b;
         default: r.status = ialu_pkg::ST_BAD_OP;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = MIN64;
         1: v = MAX64;
         2: v = '0;
         3: v = {64{1'b1}};
         4: v = 64'($urandom_range(0, 3));
         5: v = {{32{v[31]}}, v[31:0]};   // mid-size values, exercise small divisors
         default: ;
      endcase
      return v;
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 19) == 0) return int'($urandom_range(8, 40));
      if ($urandom_range(0, 2) == 0) return int'($urandom_range(1, 3));
      return 0;
   endfunction

   // Offer one transaction; hold it until accepted, then optionally idle.
   task automatic send_op(ialu_pkg::op_type op, logic [63:0] a, logic [63:0] b,
                          logic [63:0] sc, bit gaps = 1'b1);
      int gap;
      req_tdata  <= {3'b000, sc, b, a, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(alu_predict(op, a, b, sc));
      gap = gaps ? rand_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Response side: random backpressure, plus a forced long stall on request.
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_en) gap = rand_gap();
         end
      end
   end

   // Checker: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_q.size() == 0) begin
            $error("unexpected transaction: result_value %h status_code %0d",
                   rsp_tdata[63:0], rsp_tdata[65:64]);
            error_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_tdata[63:0] !== exp_r.value) begin
               $error("result_value: expected %h actual %h", exp_r.value, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[65:64] !== exp_r.status) begin
               $error("status_code: expected %0d actual %0d", exp_r.status,
                      rsp_tdata[65:64]);
               error_count++;
            end
         end
      end
   end

   task automatic test_opcodes();
      ialu_pkg::op_type op;
      for (int i = 0; i <= int'(ialu_pkg::OP_XOR); i++) begin
         op = ialu_pkg::op_type'(i);
         send_op(op, 64'd100, 64'd7, 64'd3);
      end
      send_op(ialu_pkg::op_type'(5'd17), 64'd1, 64'd2, 64'd3);   // unknown opcodes
      send_op(ialu_pkg::op_type'(5'd31), MAX64, MIN64, MAX64);
   endtask

   task automatic test_corners();
      send_op(ialu_pkg::OP_DIV, 64'd5, 64'd0, 64'd0);              // divide by zero
      send_op(ialu_pkg::OP_REM, MIN64, 64'd0, 64'd0);
      send_op(ialu_pkg::OP_DIV, MIN64, {64{1'b1}}, 64'd0);         // most negative / -1
      send_op(ialu_pkg::OP_REM, MIN64, {64{1'b1}}, 64'd0);
      send_op(ialu_pkg::OP_DIV, -64'sd7, 64'd2, 64'd0);            // truncation, remainder sign
      send_op(ialu_pkg::OP_REM, -64'sd7, 64'd2, 64'd0);
      send_op(ialu_pkg::OP_REM, 64'd7, -64'sd2, 64'd0);
      send_op(ialu_pkg::OP_ADD, MAX64, 64'd1, 64'd0);              // wrap
      send_op(ialu_pkg::OP_MULH, MIN64, MIN64, 64'd0);
      send_op(ialu_pkg::OP_MAD, MAX64, MAX64, MIN64);
      send_op(ialu_pkg::OP_SHL, MAX64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);  // low 6 bits count
      send_op(ialu_pkg::OP_SAR, MIN64, 64'd63, 64'd0);
      send_op(ialu_pkg::OP_SHR, MIN64, 64'd63, 64'd0);
      send_op(ialu_pkg::OP_LT, MIN64, MAX64, 64'd0);               // signed compares
      send_op(ialu_pkg::OP_LE, MAX64, MAX64, 64'd0);
      send_op(ialu_pkg::OP_EQ, {64{1'b1}}, {64{1'b1}}, 64'd0);
   endtask

   task automatic test_random(int count);
      ialu_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 15) == 0) ? ialu_pkg::op_type'($urandom_range(17, 31))
                                            : ialu_pkg::op_type'($urandom_range(0, 16));
         send_op(op, rand64(), rand64(), rand64());
      end
   endtask

   // Receiver stalls long while items keep coming: the pipe fills and req_tready drops.
   task automatic test_backpressure();
      hold_cycles = 3 * LATENCY;
      for (int i = 0; i < 120; i++)
         send_op(ialu_pkg::op_type'($urandom_range(0, 16)), rand64(), rand64(), rand64(),
                 1'b0);
      drain();
   endtask

   // Back-to-back traffic with the receiver always ready.
   task automatic test_streaming();
      rsp_idle_en = 1'b0;
      for (int i = 0; i < 150; i++)
         send_op(ialu_pkg::op_type'($urandom_range(0, 16)), rand64(), rand64(), rand64(),
                 1'b0);
      drain();
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_opcodes();
      test_corners();
      drain();                  // sender pauses until every result is back
      test_random(200);
      test_backpressure();
      test_streaming();
      test_random(230);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered all opcodes, unknown opcodes, divide corners and shift wrap;");
      $display("%0d results checked under random and long output stalls", rsp_count);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("tb_integer_alu_64bit: clean");
      end else begin
         $display("tb_integer_alu_64bit: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_integer_alu_64bit: errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/ialu_pkg.sv
rtl/core/integer_alu_64bit.sv
dv/tb_integer_alu_64bit.sv
